// ===== rtl/bts_pkg.sv =====
// Shared widths, register indexes and elaboration helpers for the bilinear texture sampler.
`timescale 1ns / 1ps

package bts_pkg;

  localparam int unsigned MAX_SIDE_DEF       = 256;
  localparam int unsigned PIXEL_CAPACITY_DEF = 65536;

  localparam int SIDE_W     = 9;
  localparam int BPP_W      = 3;
  localparam int INDEX_W    = 16;
  localparam int PIXEL_W    = 32;
  localparam int POS_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int FRAC_W     = 16;
  localparam int WT_W       = 17;
  localparam int XW         = POS_W + SIDE_W;
  localparam int LO_W       = XW - FRAC_W;
  localparam int HI_W       = LO_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 2'd0,
    REG_IMAGE_HEIGHT    = 2'd1,
    REG_BYTES_PER_PIXEL = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_SAMPLE = 1'b1
  } action_t;

  // Number of compare-and-subtract steps that bring any value up to amax below cap.
  function automatic int unsigned red_steps(longint unsigned cap, longint unsigned amax);
    int unsigned k;
    k = 0;
    while ((cap << k) <= amax) begin
      k++;
    end
    return k;
  endfunction

endpackage

// ===== rtl/bts_if.sv =====
// Valid/ready channel interfaces for sample requests, results and register writes.
`timescale 1ns / 1ps

interface bts_req_if;
  import bts_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [INDEX_W-1:0] pixel_index;
  logic [PIXEL_W-1:0] pixel_value;
  logic [POS_W-1:0]   pos_u;
  logic [POS_W-1:0]   pos_v;
  modport source (output valid, action, pixel_index, pixel_value, pos_u, pos_v, input ready);
  modport sink (input valid, action, pixel_index, pixel_value, pos_u, pos_v, output ready);
endinterface

interface bts_rsp_if;
  import bts_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] sample_color;
  modport source (output valid, sample_color, input ready);
  modport sink (input valid, sample_color, output ready);
endinterface

interface bts_cfg_if;
  import bts_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bilinear_texture_sampler_top.sv =====
// Bilinear texture sampler: pixel store, shared multiplier and its sequencer.
`timescale 1ns / 1ps

// Usage
// The req channel carries two kinds of item. A load (action 0) writes pixel_value into the
// pixel store at pixel_index in the cycle of its transfer; loads beyond the store are dropped.
// A sample (action 1) carries pos_u and pos_v in 1.16 fixed point and yields one transfer on
// rsp with the interpolated color; loads yield nothing. The cfg channel is always ready and
// sets image width, height and bytes per pixel; write it only while the block is idle.
// Flow: a load leaves req ready, so the next item may follow at once. A sample keeps req
// low until its color moves into the output register. Each texel address takes R reduction
// steps (zero when the store holds MAX_SIDE squared pixels, as with the defaults). All
// multiplies run through one 33x17 multiplier, at most one operation per cycle, and the four
// texels come from the single store port, one after another. The finished color sits in an
// output register, so the next item is accepted while it waits. If the receiver still holds
// a previous color when a new one is done, the sequencer waits in its last step. Reset clears
// the sequencer and the output valid and restores the register defaults; the pixel store is
// not cleared and must be loaded before sampling.
module bilinear_texture_sampler_top #(
  parameter int unsigned MAX_SIDE       = bts_pkg::MAX_SIDE_DEF,
  parameter int unsigned PIXEL_CAPACITY = bts_pkg::PIXEL_CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bts_req_if.sink    req,
  bts_rsp_if.source  rsp,
  bts_cfg_if.sink    cfg
);
  import bts_pkg::*;

  localparam int unsigned SIDE_MAX  = (MAX_SIDE < 511) ? MAX_SIDE : 511;
  localparam int unsigned AMAX      = SIDE_MAX * SIDE_MAX - 1;
  localparam int          RAW_W     = $clog2(AMAX + 1);
  localparam int          AW        = $clog2(PIXEL_CAPACITY);
  localparam int unsigned RED_STEPS = red_steps(PIXEL_CAPACITY, AMAX);
  localparam int          RK_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int unsigned RK_INIT   = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
  localparam logic [SIDE_W-1:0] SIDE_RST = SIDE_W'((MAX_SIDE < 256) ? MAX_SIDE : 256);

  localparam int MA_W   = 33;
  localparam int MB_W   = WT_W;
  localparam int MF_W   = MA_W + MB_W;
  localparam int PROD_W = 40;

  typedef enum logic [10:0] {
    S_IDLE    = 11'h001,
    S_MUL_X   = 11'h002,
    S_MUL_Y   = 11'h004,
    S_SPLIT_Y = 11'h008,
    S_ROW     = 11'h010,
    S_ADDR    = 11'h020,
    S_RED     = 11'h040,
    S_READ    = 11'h080,
    S_LATCH   = 11'h100,
    S_WEIGHT  = 11'h200,
    S_CHAN    = 11'h400
  } state_t;

  typedef struct packed {
    logic [SIDE_W-1:0] lo;
    logic [SIDE_W-1:0] hi;
    logic [FRAC_W-1:0] frac;
  } axis_t;

  // Left and right neighbor of x - 0.5 on one axis, clamped to the image, and the fraction.
  function automatic axis_t axis_split(input logic [XW-1:0] x, input logic [SIDE_W-1:0] n);
    axis_t             r;
    logic [XW-1:0]     t;
    logic [LO_W-1:0]   lo_w;
    logic [HI_W-1:0]   hi_w;
    logic [SIDE_W-1:0] lim;
    lim = n - SIDE_W'(1);
    t   = x - XW'(32768);
    if (x < XW'(32768)) begin
      lo_w   = '0;
      hi_w   = '0;
      r.frac = FRAC_W'(x + XW'(32768));
    end else begin
      lo_w   = t[XW-1:FRAC_W];
      hi_w   = HI_W'(lo_w) + HI_W'(1);
      r.frac = t[FRAC_W-1:0];
    end
    r.lo = (lo_w > LO_W'(lim)) ? lim : lo_w[SIDE_W-1:0];
    r.hi = (hi_w > HI_W'(lim)) ? lim : hi_w[SIDE_W-1:0];
    return r;
  endfunction

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    if (s == '0) begin
      r = SIDE_W'(1);
    end else if (32'(s) > SIDE_MAX) begin
      r = SIDE_W'(SIDE_MAX);
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [1:0] clamp_last_chan(input logic [BPP_W-1:0] b);
    logic [1:0] r;
    if (b == '0) begin
      r = 2'd0;
    end else if (b > BPP_W'(4)) begin
      r = 2'd3;
    end else begin
      r = 2'(b - BPP_W'(1));
    end
    return r;
  endfunction

  state_t              state;
  logic [2:0]          sub;
  logic [1:0]          tix;
  logic [1:0]          chan;
  logic [1:0]          last_chan;
  logic [RK_W-1:0]     red_k;
  logic [SIDE_W-1:0]   w_eff;
  logic [SIDE_W-1:0]   h_eff;
  logic                out_valid;

  logic [POS_W-1:0]    u;
  logic [POS_W-1:0]    v;
  logic [SIDE_W-1:0]   x1;
  logic [SIDE_W-1:0]   x2;
  logic [SIDE_W-1:0]   y1;
  logic [SIDE_W-1:0]   y2;
  logic [WT_W-1:0]     wx1;
  logic [WT_W-1:0]     wx2;
  logic [WT_W-1:0]     wy1;
  logic [WT_W-1:0]     wy2;
  logic [RAW_W-1:0]    base1;
  logic [RAW_W-1:0]    base2;
  logic [RAW_W-1:0]    addr_raw;
  logic [PIXEL_W-1:0]  q [4];
  logic [MA_W-1:0]     wt [4];
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   prod;
  logic [PIXEL_W-1:0]  res;
  logic [PIXEL_W-1:0]  out_data;
  logic [PIXEL_W-1:0]  rd_data;
  logic [PIXEL_W-1:0]  store [PIXEL_CAPACITY];

  logic                mul_en;
  logic [MA_W-1:0]     mul_a;
  logic [MB_W-1:0]     mul_b;
  logic [MF_W-1:0]     mul_full;
  logic [PROD_W-1:0]   acc_sum;
  logic [7:0]          chan_byte;
  logic [PIXEL_W-1:0]  res_ins;
  logic [RAW_W-1:0]    red_div;
  logic                req_fire;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic                out_load;
  axis_t               split_x;
  axis_t               split_y;

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.sample_color = out_data;
  assign cfg.ready        = 1'b1;

  assign req_fire = req.valid && req.ready;
  assign mem_we   = req_fire && (req.action == ACT_LOAD)
                    && (32'(req.pixel_index) < PIXEL_CAPACITY);
  assign mem_addr = (state == S_IDLE) ? AW'(req.pixel_index) : AW'(addr_raw);

  // The last channel of a sample moves into the output register this cycle.
  assign out_load = (state == S_CHAN) && (sub == 3'd4) && (chan == last_chan)
                    && (!out_valid || rsp.ready);

  assign split_x = axis_split(prod[XW-1:0], w_eff);
  assign split_y = axis_split(prod[XW-1:0], h_eff);

  assign mul_full  = MF_W'(mul_a) * MF_W'(mul_b);
  assign acc_sum   = acc + prod;
  assign chan_byte = acc_sum[PROD_W-1:PROD_W-8];
  assign red_div   = RAW_W'(PIXEL_CAPACITY) << red_k;

  always_comb begin
    res_ins = res;
    res_ins[{chan, 3'b000} +: 8] = chan_byte;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state)
      S_MUL_X: begin
        mul_en = 1'b1;
        mul_a  = MA_W'(w_eff);
        mul_b  = u;
      end
      S_MUL_Y: begin
        mul_en = 1'b1;
        mul_a  = MA_W'(h_eff);
        mul_b  = v;
      end
      S_ROW: begin
        mul_en = (sub < 3'd2);
        mul_a  = MA_W'(w_eff);
        mul_b  = MB_W'(sub[0] ? y2 : y1);
      end
      S_WEIGHT: begin
        mul_en = !sub[2];
        mul_a  = MA_W'(sub[0] ? wx2 : wx1);
        mul_b  = sub[1] ? wy2 : wy1;
      end
      S_CHAN: begin
        mul_en = !sub[2];
        mul_a  = wt[sub[1:0]];
        mul_b  = MB_W'(q[sub[1:0]][{chan, 3'b000} +: 8]);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Single-port pixel store.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_addr] <= req.pixel_value;
    end
    rd_data <= store[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sub       <= '0;
      tix       <= '0;
      chan      <= '0;
      red_k     <= '0;
      out_valid <= 1'b0;
      w_eff     <= SIDE_RST;
      h_eff     <= SIDE_RST;
      last_chan <= 2'd3;
    end else begin
      if (rsp.valid && rsp.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (mul_en) begin
        prod <= mul_full[PROD_W-1:0];
      end

      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_IMAGE_WIDTH:     w_eff     <= clamp_side(cfg.data);
          REG_IMAGE_HEIGHT:    h_eff     <= clamp_side(cfg.data);
          REG_BYTES_PER_PIXEL: last_chan <= clamp_last_chan(cfg.data[BPP_W-1:0]);
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid && (req.action == ACT_SAMPLE)) begin
            u     <= req.pos_u;
            v     <= req.pos_v;
            res   <= '0;
            chan  <= '0;
            state <= S_MUL_X;
          end
        end
        S_MUL_X: begin
          state <= S_MUL_Y;
        end
        S_MUL_Y: begin
          x1    <= split_x.lo;
          x2    <= split_x.hi;
          wx2   <= WT_W'(split_x.frac);
          wx1   <= WT_W'(17'h10000) - WT_W'(split_x.frac);
          state <= S_SPLIT_Y;
        end
        S_SPLIT_Y: begin
          y1    <= split_y.lo;
          y2    <= split_y.hi;
          wy2   <= WT_W'(split_y.frac);
          wy1   <= WT_W'(17'h10000) - WT_W'(split_y.frac);
          sub   <= '0;
          state <= S_ROW;
        end
        S_ROW: begin
          // Row bases y1*width and y2*width are taken from the registered product of their multiply.
          if (sub == 3'd1) begin
            base1 <= prod[RAW_W-1:0];
          end
          if (sub == 3'd2) begin
            base2 <= prod[RAW_W-1:0];
            tix   <= '0;
            sub   <= '0;
            state <= S_ADDR;
          end else begin
            sub <= sub + 3'd1;
          end
        end
        S_ADDR: begin
          addr_raw <= (tix[1] ? base2 : base1) + RAW_W'(tix[0] ? x2 : x1);
          red_k    <= RK_W'(RK_INIT);
          state    <= (RED_STEPS > 0) ? S_RED : S_READ;
        end
        S_RED: begin
          // Restoring remainder by the store depth, one shifted compare per cycle.
          if (addr_raw >= red_div) begin
            addr_raw <= addr_raw - red_div;
          end
          if (red_k == '0) begin
            state <= S_READ;
          end else begin
            red_k <= red_k - RK_W'(1);
          end
        end
        S_READ: begin
          state <= S_LATCH;
        end
        S_LATCH: begin
          q[tix] <= rd_data;
          if (tix == 2'd3) begin
            sub   <= '0;
            state <= S_WEIGHT;
          end else begin
            tix   <= tix + 2'd1;
            state <= S_ADDR;
          end
        end
        S_WEIGHT: begin
          if (sub != 3'd0) begin
            wt[sub[1:0] - 2'd1] <= prod[MA_W-1:0];
          end
          if (sub == 3'd4) begin
            sub   <= '0;
            state <= S_CHAN;
          end else begin
            sub <= sub + 3'd1;
          end
        end
        S_CHAN: begin
          if (sub == 3'd1) begin
            acc <= prod;
          end
          if ((sub == 3'd2) || (sub == 3'd3)) begin
            acc <= acc_sum;
          end
          if (sub == 3'd4) begin
            if (chan == last_chan) begin
              if (!out_valid || rsp.ready) begin
                out_data  <= res_ins;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end
            end else begin
              res  <= res_ins;
              chan <= chan + 2'd1;
              sub  <= '0;
            end
          end else begin
            sub <= sub + 3'd1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/bts_checker.sv =====
// Port-level checks for the bilinear texture sampler and their bind to the top level.
`timescale 1ns / 1ps

module bts_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        req_action,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [bts_pkg::PIXEL_W-1:0] rsp_sample_color
);
  import bts_pkg::*;

  // A stalled result keeps its valid and its color.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_color))
    else $error("result changed or vanished while stalled");

  // A sample occupies the sequencer, so the request side closes right after it.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action == ACT_SAMPLE) |=> !req_ready)
    else $error("request side stayed open after a sample transfer");

  // A load finishes in its own cycle.
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_action == ACT_LOAD) |=> req_ready)
    else $error("request side closed after a load transfer");

  // A new result only appears at the end of a sample in progress.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without a sample in progress");

endmodule

bind bilinear_texture_sampler_top bts_checker u_bts_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .req_action       (req.action),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_sample_color (rsp.sample_color)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the bilinear texture sampler: directed table, random phases.
`timescale 1ns / 1ps

module tb;
  import bts_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_ITEMS   = 70;
  localparam int HOLD_CYCLES   = 400;

  typedef struct {
    bit            is_cfg;
    cfg_reg_t      reg_sel;
    bit [8:0]      reg_data;
    action_t       act;
    bit [15:0]     idx;
    bit [31:0]     pix;
    bit [16:0]     u;
    bit [16:0]     v;
    bit            has_exp;
    bit [31:0]     exp_color;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bts_req_if req_ch ();
  bts_rsp_if rsp_ch ();
  bts_cfg_if cfg_ch ();

  bilinear_texture_sampler_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #5 clk = ~clk;

  // Mirror of the block: image store, which entries hold data, and the registers.
  bit [31:0] image_mem     [0:65535];
  bit        image_written [0:65535];
  bit [8:0]  cfg_width  = 9'd256;
  bit [8:0]  cfg_height = 9'd256;
  bit [2:0]  cfg_bpp    = 3'd4;

  bit [31:0] color_queue [$];
  int        items_sent  = 0;
  int        colors_seen = 0;
  int        mismatches  = 0;
  int        stall_cycles = 0;
  bit        random_run  = 1'b0;

  function automatic int unsigned side_of(bit [8:0] s);
    if (s == 9'd0) return 1;
    if (32'(s) > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return 32'(s);
  endfunction

  // Left and right neighbor along one axis, clamped, and the weight of the right one.
  function automatic void split_axis(input bit [16:0] c, input int unsigned n,
                                     output int unsigned lo_i, output int unsigned hi_i,
                                     output int unsigned frac);
    longint unsigned x, t;
    x = 64'(c) * 64'(n);
    if (x < 64'd32768) begin
      lo_i = 0;
      hi_i = 0;
      frac = 32'(x + 64'd32768);
    end else begin
      t = x - 64'd32768;
      lo_i = 32'(t >> 16);
      hi_i = lo_i + 1;
      frac = 32'(t & 64'hFFFF);
    end
    if (lo_i > n - 1) lo_i = n - 1;
    if (hi_i > n - 1) hi_i = n - 1;
  endfunction

  // Store addresses of the four texels, ordered (x1,y1) (x2,y1) (x1,y2) (x2,y2).
  function automatic void find_neighbors(input bit [16:0] u, input bit [16:0] v,
                                         output bit [15:0] addr [4],
                                         output int unsigned fx, output int unsigned fy);
    int unsigned w, h, x1, x2, y1, y2;
    w = side_of(cfg_width);
    h = side_of(cfg_height);
    split_axis(u, w, x1, x2, fx);
    split_axis(v, h, y1, y2, fy);
    addr[0] = 16'(y1 * w + x1);
    addr[1] = 16'(y1 * w + x2);
    addr[2] = 16'(y2 * w + x1);
    addr[3] = 16'(y2 * w + x2);
  endfunction

  function automatic bit [31:0] predict_color(bit [16:0] u, bit [16:0] v);
    bit [15:0]       a [4];
    int unsigned     fx, fy, ch;
    longint unsigned wx [2];
    longint unsigned wy [2];
    bit [63:0]       acc;
    bit [31:0]       res;
    find_neighbors(u, v, a, fx, fy);
    wx[1] = 64'(fx);
    wx[0] = 64'(65536 - fx);
    wy[1] = 64'(fy);
    wy[0] = 64'(65536 - fy);
    ch = (cfg_bpp == 3'd0) ? 1 : ((cfg_bpp > 3'd4) ? 4 : 32'(cfg_bpp));
    res = '0;
    for (int k = 0; k < 4; k++) begin
      if (k < ch) begin
        acc = 64'(image_mem[a[0]][8*k +: 8]) * wx[0] * wy[0] +
              64'(image_mem[a[1]][8*k +: 8]) * wx[1] * wy[0] +
              64'(image_mem[a[2]][8*k +: 8]) * wx[0] * wy[1] +
              64'(image_mem[a[3]][8*k +: 8]) * wx[1] * wy[1];
        res[8*k +: 8] = acc[39:32];
      end
    end
    return res;
  endfunction

  // Request fields that an item does not use are filled with random noise.
  function automatic step_t blank_step();
    step_t s;
    s.is_cfg    = 1'b0;
    s.reg_sel   = REG_IMAGE_WIDTH;
    s.reg_data  = '0;
    s.act       = ACT_LOAD;
    s.idx       = 16'($urandom);
    s.pix       = $urandom;
    s.u         = 17'($urandom);
    s.v         = 17'($urandom);
    s.has_exp   = 1'b0;
    s.exp_color = '0;
    return s;
  endfunction

  function automatic step_t ld(bit [15:0] idx, bit [31:0] pix);
    step_t s;
    s     = blank_step();
    s.idx = idx;
    s.pix = pix;
    return s;
  endfunction

  function automatic step_t smp(bit [16:0] u, bit [16:0] v);
    step_t s;
    s     = blank_step();
    s.act = ACT_SAMPLE;
    s.u   = u;
    s.v   = v;
    return s;
  endfunction

  function automatic step_t smpx(bit [16:0] u, bit [16:0] v, bit [31:0] color);
    step_t s;
    s           = smp(u, v);
    s.has_exp   = 1'b1;
    s.exp_color = color;
    return s;
  endfunction

  function automatic step_t wr(cfg_reg_t r, bit [8:0] d);
    step_t s;
    s          = blank_step();
    s.is_cfg   = 1'b1;
    s.reg_sel  = r;
    s.reg_data = d;
    return s;
  endfunction

  task automatic send_item(step_t s);
    bit calm;
    @(negedge clk);
    calm = (items_sent >= 350 && items_sent < 450);
    while (!calm && $urandom_range(99) < 21) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.action      <= s.act;
    req_ch.pixel_index <= s.idx;
    req_ch.pixel_value <= s.pix;
    req_ch.pos_u       <= s.u;
    req_ch.pos_v       <= s.v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    if (s.act == ACT_LOAD) begin
      image_mem[s.idx]     = s.pix;
      image_written[s.idx] = 1'b1;
    end else begin
      color_queue.push_back(s.has_exp ? s.exp_color : predict_color(s.u, s.v));
    end
  endtask

  // Texels that were never loaded get a random value first, so no sample reads garbage.
  task automatic preload_neighbors(bit [16:0] u, bit [16:0] v);
    bit [15:0]   a [4];
    int unsigned fx, fy;
    for (int i = 0; i < 4; i++) begin
      find_neighbors(u, v, a, fx, fy);
      if (!image_written[a[i]]) send_item(ld(a[i], $urandom));
    end
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (color_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, bit [8:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (r)
      REG_IMAGE_WIDTH:     cfg_width  = d;
      REG_IMAGE_HEIGHT:    cfg_height = d;
      REG_BYTES_PER_PIXEL: cfg_bpp    = d[2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_step(step_t s);
    if (s.is_cfg) begin
      wait_quiet();
      write_reg(s.reg_sel, s.reg_data);
    end else begin
      if (s.act == ACT_SAMPLE) preload_neighbors(s.u, s.v);
      send_item(s);
    end
  endtask

  function automatic bit [16:0] pick_coord();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 17'($urandom_range(65536));
    if (r < 85) begin
      case ($urandom_range(3))
        0: return 17'd0;
        1: return 17'd65535;
        2: return 17'd65536;
        default: return 17'h1FFFF;
      endcase
    end
    return 17'($urandom_range(131071));
  endfunction

  task automatic random_step();
    int unsigned pick, col, row;
    pick = $urandom_range(99);
    if (pick < 55) begin
      run_step(smp(pick_coord(), pick_coord()));
    end else if (pick < 80) begin
      col = $urandom_range(side_of(cfg_width) - 1);
      row = $urandom_range(side_of(cfg_height) - 1);
      run_step(ld(16'(row * side_of(cfg_width) + col), $urandom));
    end else begin
      run_step(ld(16'($urandom), $urandom));
    end
  endtask

  // Receiver: random stalls, a calm stretch, and one long hold-off that backs up the block.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && random_run && items_sent > 150 && color_queue.size() > 0) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (colors_seen >= 200 && colors_seen < 260) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= 21);
      end
    end
  end

  always @(posedge clk) begin
    bit [31:0] want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      colors_seen++;
      if (color_queue.size() == 0) begin
        mismatches++;
        $display("%0t: sample_color expected none, actual %h", $time, rsp_ch.sample_color);
      end else begin
        want = color_queue.pop_front();
        if (rsp_ch.sample_color !== want) begin
          mismatches++;
          $display("%0t: sample_color expected %h, actual %h", $time, want,
                   rsp_ch.sample_color);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    step_t    script [$];
    bit [8:0] w, h;
    bit [2:0] b;
    int       phase_start;

    req_ch.valid       = 1'b0;
    req_ch.action      = ACT_LOAD;
    req_ch.pixel_index = '0;
    req_ch.pixel_value = '0;
    req_ch.pos_u       = '0;
    req_ch.pos_v       = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_IMAGE_WIDTH;
    cfg_ch.data        = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Starts from the reset shape, 256 by 256 with four channels.
    script = '{
      ld(16'd0, 32'hDEADBEEF),
      ld(16'd65535, 32'hFFFFFFFF),
      ld(16'd1, 32'h00000000),
      smpx(17'd0, 17'd0, 32'hDEADBEEF),
      smpx(17'd65536, 17'd65536, 32'hFFFFFFFF),
      smpx(17'h1FFFF, 17'h1FFFF, 32'hFFFFFFFF),
      smpx(17'd256, 17'd0, 32'h6F565F77),
      smp(17'd0, 17'd65535),
      smp(17'd32768, 17'd32768),
      smp(17'd65535, 17'd1),
      ld(16'd256, 32'h12345678),
      smp(17'd0, 17'd256),
      wr(REG_BYTES_PER_PIXEL, 9'd1),
      smpx(17'd0, 17'd0, 32'h000000EF),
      wr(REG_BYTES_PER_PIXEL, 9'd0),
      smpx(17'd0, 17'd0, 32'h000000EF),
      wr(REG_BYTES_PER_PIXEL, 9'd3),
      smpx(17'd0, 17'd0, 32'h00ADBEEF),
      wr(REG_BYTES_PER_PIXEL, 9'd7),
      smpx(17'd0, 17'd0, 32'hDEADBEEF),
      wr(REG_IMAGE_WIDTH, 9'd1),
      wr(REG_IMAGE_HEIGHT, 9'd1),
      smpx(17'd65536, 17'd65536, 32'hDEADBEEF),
      smpx(17'h1FFFF, 17'd0, 32'hDEADBEEF),
      wr(REG_IMAGE_WIDTH, 9'd0),
      wr(REG_IMAGE_HEIGHT, 9'd0),
      smpx(17'd32768, 17'd65535, 32'hDEADBEEF),
      wr(REG_IMAGE_WIDTH, 9'd511),
      wr(REG_IMAGE_HEIGHT, 9'd300),
      smpx(17'd65536, 17'd65536, 32'hFFFFFFFF)
    };
    foreach (script[i]) run_step(script[i]);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin w = 9'd1;   h = 9'd1;   b = 3'd1; end
        1: begin w = 9'd256; h = 9'd256; b = 3'd4; end
        2: begin w = 9'd511; h = 9'd0;   b = 3'd7; end
        3: begin w = 9'd2;   h = 9'd3;   b = 3'd2; end
        4: begin w = 9'd17;  h = 9'd9;   b = 3'd3; end
        5: begin w = 9'd1;   h = 9'd256; b = 3'd4; end
        6: begin
          w = 9'($urandom_range(1, 40));
          h = 9'($urandom_range(1, 40));
          b = 3'($urandom_range(7));
        end
        default: begin
          w = 9'($urandom_range(511));
          h = 9'($urandom_range(511));
          b = 3'($urandom_range(7));
        end
      endcase
      run_step(wr(REG_IMAGE_WIDTH, w));
      run_step(wr(REG_IMAGE_HEIGHT, h));
      run_step(wr(REG_BYTES_PER_PIXEL, {6'd0, b}));
      random_run  = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) random_step();
      random_run = 1'b0;
    end

    wait_quiet();
    if (mismatches == 0 && color_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
